/* hdl/fnv_pkg.sv */
// shared constants, types and helper functions for the fnv-1a text fingerprint
package fnv_pkg;

  localparam int unsigned HASH_W = 64;
  localparam int unsigned BYTE_W = 8;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

  localparam logic [BYTE_W-1:0] MARK_0 = 8'hEF;
  localparam logic [BYTE_W-1:0] MARK_1 = 8'hBB;
  localparam logic [BYTE_W-1:0] MARK_2 = 8'hBF;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;

  // prime 0x100000001B3 = 1 + 2^1 + 2^4 + 2^5 + 2^7 + 2^8 + 2^40
  // the unit starts from the operand itself and adds one shifted copy per step
  localparam int unsigned MUL_STEPS = 6;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] product;
  } mul_rsp_t;

  function automatic logic [5:0] mul_shift(input logic [MUL_CNT_W-1:0] idx);
    logic [5:0] s;
    case (idx)
      3'd0:    s = 6'd1;
      3'd1:    s = 6'd4;
      3'd2:    s = 6'd5;
      3'd3:    s = 6'd7;
      3'd4:    s = 6'd8;
      default: s = 6'd40;
    endcase
    return s;
  endfunction

  function automatic logic [BYTE_W-1:0] mark_byte(input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      2'd0:    b = MARK_0;
      2'd1:    b = MARK_1;
      default: b = MARK_2;
    endcase
    return b;
  endfunction

endpackage

/* hdl/fnv_if.sv */
// valid/ready channel interfaces for message bytes and fingerprints
interface fnv_in_if
  import fnv_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_present;
  logic              last;

  modport source (output valid, data_byte, byte_present, last, input ready);
  modport sink   (input valid, data_byte, byte_present, last, output ready);
endinterface

interface fnv_out_if
  import fnv_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] fingerprint;

  modport source (output valid, fingerprint, input ready);
  modport sink   (input valid, fingerprint, output ready);
endinterface

/* hdl/fnv_mul.sv */
// shift-add unit multiplying a 64-bit operand by the fnv prime, one add per cycle
module fnv_mul
  import fnv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [MUL_CNT_W-1:0] cnt;
  logic [HASH_W-1:0]    opnd;
  logic [HASH_W-1:0]    acc;

  localparam logic [MUL_CNT_W-1:0] CNT_LAST = MUL_CNT_W'(MUL_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        opnd <= req.operand;
        acc  <= req.operand;
      end else if (busy) begin
        acc <= acc + (opnd << mul_shift(cnt));
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

/* hdl/fnv1a64_text_fingerprint.sv */
// top level: byte normaliser, mark-prefix handling and hash sequencer
//  - msg channel: one item per raw message byte (data_byte with byte_present
//    high); last high ends the message, and an item with byte_present low and
//    last high closes a message without adding a byte (covers the empty one)
//  - fp channel: one item per message, the 64-bit fnv-1a hash of the
//    normalised text, never zero (a zero hash is given as one)
//  - a leading ef bb bf mark is skipped; held mark bytes are hashed once the
//    match breaks or the message ends; cr is hashed as lf, an lf right after
//    a cr is dropped
//  - sequencing: msg.ready is high only while the sequencer is idle; an
//    item passes an accept step, a dispatch step per byte it releases (up to
//    three: two held mark bytes and the byte itself), the six-step shift-add
//    prime multiply per hashed byte (none for a dropped lf) and a closing step
//  - on a last item the closing step loads the result register, which is
//    offered from the next cycle and waits there until fp.ready; no new item
//    is taken meanwhile, so a stalled receiver stalls the sender
//  - reset (synchronous, active high) returns the hash to the offset basis,
//    clears the prefix tracking and drops any pending result
module fnv1a64_text_fingerprint
  import fnv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  fnv_in_if.sink      msg,
  fnv_out_if.source   fp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT,
    S_OUT
  } state_t;

  state_t            state;
  logic [HASH_W-1:0] hash;
  logic [1:0]        phase;       // mark bytes matched and held back
  logic              decided;     // mark found or ruled out
  logic              drop_lf;     // previous hashed byte was a cr
  logic [1:0]        flush_cnt;   // held mark bytes to release
  logic [1:0]        flush_idx;
  logic              byte_pend;
  logic              last_pend;
  logic [BYTE_W-1:0] byte_reg;
  logic [HASH_W-1:0] fp_reg;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // accept-side decode
  logic in_acc;
  logic match;
  logic complete;

  // dispatch-side decode
  logic              feed_go;
  logic              feed_mark;
  logic [BYTE_W-1:0] feed_byte;
  logic              feed_drop;
  logic [BYTE_W-1:0] feed_norm;

  assign msg.ready = (state == S_IDLE);
  assign in_acc    = msg.valid && msg.ready;

  assign match = msg.byte_present && !decided && (phase != 2'd3) &&
                 (msg.data_byte == mark_byte(phase));
  assign complete = match && (phase == 2'd2);

  always_comb begin
    feed_mark = (flush_idx < flush_cnt);
    feed_go   = (state == S_RUN) && (feed_mark || byte_pend);
    feed_byte = feed_mark ? mark_byte(flush_idx) : byte_reg;
    feed_drop = drop_lf && (feed_byte == CH_LF);
    feed_norm = (feed_byte == CH_CR) ? CH_LF : feed_byte;
  end

  assign mul_req.start   = feed_go && !feed_drop;
  assign mul_req.operand = hash ^ {{(HASH_W-BYTE_W){1'b0}}, feed_norm};

  fnv_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hash      <= FNV_BASIS;
      phase     <= 2'd0;
      decided   <= 1'b0;
      drop_lf   <= 1'b0;
      flush_cnt <= 2'd0;
      flush_idx <= 2'd0;
      byte_pend <= 1'b0;
      last_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            byte_reg  <= msg.data_byte;
            last_pend <= msg.last;
            flush_idx <= 2'd0;
            state     <= S_RUN;
            if (match) begin
              byte_pend <= 1'b0;
              if (complete) begin
                // whole mark seen: swallow it
                decided   <= 1'b1;
                phase     <= 2'd0;
                flush_cnt <= 2'd0;
              end else if (msg.last) begin
                // message ends inside a partial mark
                decided   <= 1'b1;
                phase     <= 2'd0;
                flush_cnt <= phase + 2'd1;
              end else begin
                phase     <= phase + 2'd1;
                flush_cnt <= 2'd0;
              end
            end else begin
              byte_pend <= msg.byte_present;
              if (!decided && (msg.byte_present || msg.last)) begin
                // match broken: release what is held, then the byte
                decided   <= 1'b1;
                phase     <= 2'd0;
                flush_cnt <= phase;
              end else begin
                flush_cnt <= 2'd0;
              end
            end
          end
        end
        S_RUN: begin
          if (feed_go) begin
            if (feed_mark) begin
              flush_idx <= flush_idx + 2'd1;
            end else begin
              byte_pend <= 1'b0;
            end
            if (feed_drop) begin
              drop_lf <= 1'b0;
            end else begin
              drop_lf <= (feed_byte == CH_CR);
              state   <= S_WAIT;
            end
          end else if (last_pend) begin
            fp_reg  <= (hash == '0) ? HASH_W'(1) : hash;
            hash    <= FNV_BASIS;
            phase   <= 2'd0;
            decided <= 1'b0;
            drop_lf <= 1'b0;
            state   <= S_OUT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_WAIT: begin
          if (mul_rsp.done) begin
            hash  <= mul_rsp.product;
            state <= S_RUN;
          end
        end
        S_OUT: begin
          if (fp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign fp.valid       = (state == S_OUT);
  assign fp.fingerprint = fp_reg;

endmodule

/* hdl/fnv_checker.sv */
// port-level checks on the fingerprint block, bound to the top level
module fnv_checker
  import fnv_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [HASH_W-1:0] fingerprint
);

  // a result is never zero
  a_fp_nonzero : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fingerprint != '0))
    else $error("fingerprint of zero offered");

  // a stalled result holds its value
  a_fp_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(fingerprint)))
    else $error("stalled fingerprint changed or vanished");

  // no new item is taken while a result waits
  a_no_accept_on_out : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // a taken result is not offered again
  a_single_result : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result repeated after hand-off");

  // reset drops any pending result
  a_reset_clears : assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind fnv1a64_text_fingerprint fnv_checker u_fnv_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (msg.valid),
  .in_ready    (msg.ready),
  .out_valid   (fp.valid),
  .out_ready   (fp.ready),
  .fingerprint (fp.fingerprint)
);

/* tb/sv/fnv1a64_text_fingerprint_checker.sv */
`timescale 1ns / 1ps
// checker: watches both channels, predicts fingerprints and compares them
module fnv1a64_text_fingerprint_checker
  import fnv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  fnv_in_if           msg,
  fnv_out_if          fp,
  output int unsigned mismatches,
  output int unsigned pending
);

  localparam logic [HASH_W-1:0] FNV_PRIME = 64'h0000_0100_0000_01B3;
  localparam logic [2:0][BYTE_W-1:0] BOM_SEQ = {MARK_2, MARK_1, MARK_0};

  logic [HASH_W-1:0] acc_hash;
  logic [1:0]        mark_seen;
  logic              mark_settled;
  logic              lf_swallow;
  logic [HASH_W-1:0] fingerprint_q[$];
  logic [HASH_W-1:0] want_fp;

  task automatic clear_message();
    acc_hash     = FNV_BASIS;
    mark_seen    = 2'd0;
    mark_settled = 1'b0;
    lf_swallow   = 1'b0;
  endtask

  // cr folds to lf, an lf straight after a cr disappears
  task automatic mix_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    v = b;
    if (lf_swallow && v == CH_LF) begin
      lf_swallow = 1'b0;
      return;
    end
    lf_swallow = 1'b0;
    if (v == CH_CR) begin
      v          = CH_LF;
      lf_swallow = 1'b1;
    end
    acc_hash = (acc_hash ^ {{(HASH_W-BYTE_W){1'b0}}, v}) * FNV_PRIME;
  endtask

  task automatic release_held();
    int unsigned k;
    for (k = 0; k < mark_seen; k++) mix_byte(BOM_SEQ[k[1:0]]);
    mark_seen    = 2'd0;
    mark_settled = 1'b1;
  endtask

  task automatic absorb_byte(input logic [BYTE_W-1:0] b);
    if (!mark_settled) begin
      if (mark_seen < 2'd3 && b == BOM_SEQ[mark_seen]) begin
        if (mark_seen == 2'd2) begin
          mark_seen    = 2'd0;
          mark_settled = 1'b1;
        end else begin
          mark_seen = mark_seen + 2'd1;
        end
        return;
      end
      release_held();
    end
    mix_byte(b);
  endtask

  initial begin
    mismatches = 0;
    pending    = 0;
    clear_message();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_message();
      fingerprint_q.delete();
    end else begin
      if (fp.valid && fp.ready) begin
        if (fingerprint_q.size() == 0) begin
          $error("fingerprint: expected none, actual %h", fp.fingerprint);
          mismatches++;
        end else begin
          want_fp = fingerprint_q.pop_front();
          if (fp.fingerprint !== want_fp) begin
            $error("fingerprint: expected %h, actual %h", want_fp, fp.fingerprint);
            mismatches++;
          end
        end
      end
      if (msg.valid && msg.ready) begin
        if (msg.byte_present) absorb_byte(msg.data_byte);
        if (msg.last) begin
          if (!mark_settled) release_held();
          fingerprint_q.push_back((acc_hash == '0) ? 64'd1 : acc_hash);
          clear_message();
        end
      end
    end
    pending = fingerprint_q.size();
  end

endmodule

/* tb/sv/fnv1a64_text_fingerprint_tb.sv */
`timescale 1ns / 1ps
// testbench top: clock, reset, message stimulus, receiver stalls and verdict
module fnv1a64_text_fingerprint_tb;
  import fnv_pkg::*;

  // random part stops once this many items have gone in
  localparam int unsigned ITEM_TARGET = 1300;
  // limit covers the slowest item plus gaps and stalls, with ample margin
  localparam int unsigned CYCLE_LIMIT = 600000;
  // quiet cycles after the last fingerprint, covers a dropped-lf tail
  localparam int unsigned SETTLE_CYCLES = 40;

  logic        clk;
  logic        rst;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned items_sent;
  int unsigned cycle_count = 0;
  logic        calm_tail;     // last part of the run: no idling anywhere
  logic        no_gaps;       // sender offers back to back
  logic        hold_request;  // asks the receiver for one long hold-off

  fnv_in_if  msg_ch ();
  fnv_out_if fp_ch ();

  fnv1a64_text_fingerprint i_dut (
    .clk (clk),
    .rst (rst),
    .msg (msg_ch),
    .fp  (fp_ch)
  );

  fnv1a64_text_fingerprint_checker u_fp_check (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg_ch),
    .fp         (fp_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one item on the message channel: hold it until taken, then maybe idle
  task automatic offer(input logic [BYTE_W-1:0] b, input logic present, input logic fin);
    msg_ch.valid        <= 1'b1;
    msg_ch.data_byte    <= b;
    msg_ch.byte_present <= present;
    msg_ch.last         <= fin;
    do @(posedge clk); while (!msg_ch.ready);
    items_sent++;
    if (!calm_tail && !no_gaps && $urandom_range(0, 5) == 0) begin
      // idle burst with junk on the payload lines
      msg_ch.valid        <= 1'b0;
      msg_ch.data_byte    <= BYTE_W'($urandom);
      msg_ch.byte_present <= 1'($urandom);
      msg_ch.last         <= 1'($urandom);
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // skewed towards mark bytes, cr and lf so the normaliser gets exercised
  function automatic logic [BYTE_W-1:0] pick_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom);
    if ($urandom_range(0, 99) < 35) begin
      case ($urandom_range(0, 4))
        0:       b = MARK_0;
        1:       b = MARK_1;
        2:       b = MARK_2;
        3:       b = CH_CR;
        default: b = CH_LF;
      endcase
    end
    return b;
  endfunction

  // one whole message: optional full or partial mark, body, end item
  task automatic random_message();
    int unsigned len;
    int unsigned k;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    case ($urandom_range(0, 7))
      0: begin
        offer(MARK_0, 1'b1, 1'b0);
        offer(MARK_1, 1'b1, 1'b0);
        offer(MARK_2, 1'b1, 1'b0);
      end
      1: offer(MARK_0, 1'b1, 1'b0);
      2: begin
        offer(MARK_0, 1'b1, 1'b0);
        offer(MARK_1, 1'b1, 1'b0);
      end
      default: ;
    endcase
    for (k = 0; k < len; k++) begin
      // now and then an item with no byte and no end
      if ($urandom_range(0, 15) == 0) offer(BYTE_W'($urandom), 1'b0, 1'b0);
      offer(pick_byte(), 1'b1, 1'b0);
    end
    if ($urandom_range(0, 3) == 0) offer(BYTE_W'($urandom), 1'b0, 1'b1);
    else offer(pick_byte(), 1'b1, 1'b1);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int unsigned n;
    logic        hold_taken;
    hold_taken = 1'b0;
    fp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        fp_ch.ready <= 1'b0;
        n = 400;
      end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
        fp_ch.ready <= 1'b0;
        n = $urandom_range(1, 5);
      end else begin
        fp_ch.ready <= 1'b1;
        n = $urandom_range(1, 8);
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    logic held_once;
    logic drained_once;
    items_sent          = 0;
    calm_tail           = 1'b0;
    no_gaps             = 1'b0;
    hold_request        = 1'b0;
    held_once           = 1'b0;
    drained_once        = 1'b0;
    rst                 <= 1'b1;
    msg_ch.valid        <= 1'b0;
    msg_ch.data_byte    <= '0;
    msg_ch.byte_present <= 1'b0;
    msg_ch.last         <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message: just an end item with no byte
    offer(8'hFF, 1'b0, 1'b1);
    // full mark skipped, then the byte extremes
    offer(MARK_0, 1'b1, 1'b0);
    offer(MARK_1, 1'b1, 1'b0);
    offer(MARK_2, 1'b1, 1'b0);
    offer(8'h00, 1'b1, 1'b0);
    offer(8'hFF, 1'b1, 1'b1);
    // partial mark still held when the message ends
    offer(MARK_0, 1'b1, 1'b0);
    offer(MARK_1, 1'b1, 1'b0);
    offer(8'h00, 1'b0, 1'b1);
    // partial mark broken by a cr, cr-lf pair, idle item, lone lf,
    // and a mark that is not at the start
    offer(MARK_0, 1'b1, 1'b0);
    offer(MARK_1, 1'b1, 1'b0);
    offer(CH_CR, 1'b1, 1'b0);
    offer(CH_LF, 1'b1, 1'b0);
    offer(8'h5A, 1'b0, 1'b0);
    offer(CH_LF, 1'b1, 1'b0);
    offer(MARK_0, 1'b1, 1'b0);
    offer(MARK_1, 1'b1, 1'b0);
    offer(MARK_2, 1'b1, 1'b1);
    // eight bytes whose plain hash comes out as zero, given as one
    offer(8'hD5, 1'b1, 1'b0);
    offer(8'h6B, 1'b1, 1'b0);
    offer(8'hB9, 1'b1, 1'b0);
    offer(8'h53, 1'b1, 1'b0);
    offer(8'h42, 1'b1, 1'b0);
    offer(8'h87, 1'b1, 1'b0);
    offer(8'h08, 1'b1, 1'b0);
    offer(8'h36, 1'b1, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent + 150 >= ITEM_TARGET) calm_tail = 1'b1;
      if (!held_once && items_sent >= 400) begin
        // receiver sits on a result while messages keep coming
        held_once    = 1'b1;
        hold_request = 1'b1;
        no_gaps      = 1'b1;
        repeat (6) random_message();
        no_gaps      = 1'b0;
      end
      if (!drained_once && items_sent >= 800) begin
        // sender waits for every outstanding fingerprint
        drained_once = 1'b1;
        msg_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      random_message();
    end
    msg_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* fnv1a64_text_fingerprint.f */
hdl/fnv_pkg.sv
hdl/fnv_if.sv
hdl/fnv_mul.sv
hdl/fnv1a64_text_fingerprint.sv
hdl/fnv_checker.sv
tb/sv/fnv1a64_text_fingerprint_checker.sv
tb/sv/fnv1a64_text_fingerprint_tb.sv
